### src/sbpa_pkg.sv
package sbpa_pkg;

  localparam int unsigned DefNumBins  = 160;
  localparam logic [15:0] EmptyNoise  = 16'hFFFF;
  localparam int unsigned DivW        = 33;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_START = 2'd0,
    REG_END   = 2'd1,
    REG_STEP  = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV0,
    S_WAIT0,
    S_RD,
    S_RDW,
    S_UPD,
    S_DIV1,
    S_WAIT1,
    S_FILL,
    S_CLR,
    S_RRD,
    S_RRDW,
    S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

### src/sbpa_if.sv
interface sbpa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] frequency;
  logic [15:0] signal_level;
  logic [15:0] noise_level;
  logic        squelch_open;
  logic [7:0]  read_bin;
  modport source (output valid, op, frequency, signal_level, noise_level, squelch_open,
                  read_bin, input ready);
  modport sink (input valid, op, frequency, signal_level, noise_level, squelch_open,
                read_bin, output ready);
endinterface

interface sbpa_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  bin_index;
  logic [15:0] bin_peak;
  logic [15:0] bin_noise;
  logic        bin_marker;
  logic [7:0]  filled_bins;
  modport source (output valid, bin_index, bin_peak, bin_noise, bin_marker, filled_bins,
                  input ready);
  modport sink (input valid, bin_index, bin_peak, bin_noise, bin_marker, filled_bins,
                output ready);
endinterface

### src/spectrum_bin_peak_accumulator.sv
// An add divides twice, updates its bin and fills the following bins below the end bin before
// its result is valid; a clear writes every bin; a read does one memory read.
// One item at a time; the next item is taken only after the result transfer. A shared
// 33-bit restoring divider is run twice per add.
// Synchronous active-low reset; after reset a clearing pass
// empties the bin memory before the first item is taken.
module spectrum_bin_peak_accumulator
  import sbpa_pkg::*;
#(
  parameter int unsigned NUM_BINS = DefNumBins
) (
  input  logic        clk,
  input  logic        rst_n,
  sbpa_in_if.sink     in_ch,
  sbpa_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam logic [7:0] NbM1 = 8'(NUM_BINS - 1);
  localparam logic [7:0] Nb   = 8'(NUM_BINS);

  logic [31:0] start_r, end_r, step_r;
  reg_idx_t    ridx;
  assign ridx       = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      end_r   <= '0;
      step_r  <= 32'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (ridx)
        REG_START: start_r <= cfg_pwdata;
        REG_END:   end_r   <= cfg_pwdata;
        REG_STEP:  step_r  <= cfg_pwdata;
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_START: cfg_prdata = start_r;
      REG_END:   cfg_prdata = end_r;
      REG_STEP:  cfg_prdata = step_r;
      default:   cfg_prdata = '0;
    endcase
  end

  state_t      st_r, st_nxt;
  logic [31:0] freq_r;
  logic [15:0] sig_r, nz_r, pk_r, nzo_r;
  logic        open_r, mk_r;
  logic [7:0]  rb_r, x_r, nx_r, xl_r, last_r, fill_r, idx_r;
  logic        ovalid_r;

  logic [32:0] lo, hi, fsel, offs, span;
  logic        empty;
  logic        use2;
  assign lo    = {1'b0, start_r};
  assign hi    = {1'b0, end_r} + {1'b0, step_r};
  assign empty = hi <= lo;
  assign span  = hi - lo;
  assign fsel  = use2 ? ({1'b0, freq_r} + {1'b0, step_r}) : {1'b0, freq_r};
  assign offs  = (fsel < lo) ? 33'd0 : ((fsel > hi) ? span : fsel - lo);

  logic       div_start;
  div_ctl_t   dctl;
  logic [7:0] quot, qbin;
  sbpa_div #(.NUM_BINS(NUM_BINS)) u_div (
    .clk, .rst_n, .start(div_start), .offs, .span, .ctl(dctl), .quot
  );
  assign qbin = empty ? 8'd0 : quot;

  logic        we;
  logic [7:0]  waddr, raddr;
  logic [32:0] wdata, rdata;
  sbpa_store #(.NUM_BINS(NUM_BINS)) u_store (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  logic [15:0] cpk, cnz;
  logic        cmk;
  always_comb begin
    if (x_r != last_r) begin
      cpk = 16'd0; cnz = EmptyNoise; cmk = 1'b0;
    end else begin
      cpk = rdata[32:17]; cnz = rdata[16:1]; cmk = rdata[0];
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (in_ch.valid) begin
        case (op_t'(in_ch.op))
          OP_ADD:   st_nxt = S_DIV0;
          OP_CLEAR: st_nxt = S_CLR;
          default:  st_nxt = S_RRD;
        endcase
      end
      S_DIV0:  st_nxt = S_WAIT0;
      S_WAIT0: if (dctl.done) st_nxt = S_RD;
      S_RD:    st_nxt = S_RDW;
      S_RDW:   st_nxt = S_UPD;
      S_UPD:   st_nxt = S_DIV1;
      S_DIV1:  st_nxt = S_WAIT1;
      S_WAIT1: if (dctl.done) st_nxt = S_FILL;
      S_FILL:  if (nx_r >= xl_r || nx_r >= Nb) st_nxt = S_OUT;
      S_CLR:   if (nx_r == NbM1) st_nxt = S_OUT;
      S_RRD:   st_nxt = S_RRDW;
      S_RRDW:  st_nxt = S_OUT;
      S_OUT:   if (!ovalid_r) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    div_start   = st_r == S_DIV0 || st_r == S_DIV1;
    use2        = st_r == S_DIV1;
    in_ch.ready = st_r == S_IDLE;
    we    = 1'b0;
    waddr = x_r;
    wdata = {pk_r, nzo_r, mk_r};
    raddr = x_r;
    case (st_r)
      S_RRD: raddr = rb_r;
      S_UPD: begin
        we    = 1'b1;
        wdata = {(sig_r > cpk) ? sig_r : cpk, (nz_r < cnz) ? nz_r : cnz, cmk | open_r};
      end
      S_FILL: begin
        we    = nx_r < xl_r && nx_r < Nb;
        waddr = nx_r;
      end
      S_CLR: begin
        we    = 1'b1;
        waddr = nx_r;
        wdata = {16'd0, EmptyNoise, 1'b0};
      end
      default: ;
    endcase
  end

  logic clr_op_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_CLR;
      nx_r     <= '0;
      last_r   <= 8'hFF;
      fill_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
      case (st_r)
        S_IDLE: if (in_ch.valid) begin
          nx_r <= '0;
          if (op_t'(in_ch.op) == OP_CLEAR) fill_r <= '0;
        end
        S_WAIT0: if (dctl.done) x_r <= qbin;
        S_UPD: begin
          last_r <= x_r;
          pk_r   <= wdata[32:17];
          nzo_r  <= wdata[16:1];
          mk_r   <= wdata[0];
          nx_r   <= x_r + 8'd1;
          if (x_r > fill_r) fill_r <= x_r + 8'd1;
          idx_r  <= x_r;
        end
        S_WAIT1: if (dctl.done) xl_r <= qbin;
        S_FILL: begin
          nx_r <= nx_r + 8'd1;
          if (st_nxt == S_OUT) ovalid_r <= 1'b1;
        end
        S_CLR: begin
          nx_r <= nx_r + 8'd1;
          // reset clearing pass ends silently; a clear op reports
          if (st_nxt == S_OUT) begin
            idx_r <= '0; pk_r <= '0; nzo_r <= EmptyNoise; mk_r <= 1'b0;
            ovalid_r <= clr_op_r;
          end
        end
        S_RRDW: begin
          idx_r    <= rb_r;
          ovalid_r <= 1'b1;
          if (rb_r < Nb) begin
            pk_r <= rdata[32:17]; nzo_r <= rdata[16:1]; mk_r <= rdata[0];
          end else begin
            pk_r <= '0; nzo_r <= EmptyNoise; mk_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
    if (st_r == S_IDLE) begin
      freq_r <= in_ch.frequency;
      sig_r  <= in_ch.signal_level;
      nz_r   <= in_ch.noise_level;
      open_r <= in_ch.squelch_open;
      rb_r   <= in_ch.read_bin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_op_r <= 1'b0;
    else if (st_r == S_IDLE && in_ch.valid) clr_op_r <= op_t'(in_ch.op) == OP_CLEAR;
  end

  assign out_ch.valid       = ovalid_r;
  assign out_ch.bin_index   = idx_r;
  assign out_ch.bin_peak    = pk_r;
  assign out_ch.bin_noise   = nzo_r;
  assign out_ch.bin_marker  = mk_r;
  assign out_ch.filled_bins = fill_r;
endmodule

### src/sbpa_div.sv
// restoring divider, one quotient bit a cycle; quotient is the bin index
module sbpa_div
  import sbpa_pkg::*;
#(
  parameter int unsigned NUM_BINS = DefNumBins
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DivW-1:0] offs,
  input  logic [DivW-1:0] span,
  output div_ctl_t        ctl,
  output logic [7:0]      quot
);
  localparam int unsigned MulW = DivW + 8;
  localparam int unsigned CntW = $clog2(MulW + 1);
  localparam logic [7:0]  Nm1  = 8'(NUM_BINS - 1);

  logic [MulW-1:0] num_r, num_nxt;
  logic [DivW:0]   rem_r, rem_nxt;
  logic [DivW-1:0] den_r, den_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt, done_r, done_nxt;
  logic [DivW:0]   trial;

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DivW-1:0], num_r[MulW-1]};
    if (start) begin
      num_nxt  = MulW'(offs) * MulW'(Nm1);
      rem_nxt  = '0;
      den_nxt  = span;
      cnt_nxt  = CntW'(MulW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        num_nxt = {num_r[MulW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        num_nxt = {num_r[MulW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CntW'(1);
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign ctl  = '{start: start, busy: busy_r, done: done_r};
  assign quot = num_r[7:0];
endmodule

### src/sbpa_store.sv
module sbpa_store
  import sbpa_pkg::*;
#(
  parameter int unsigned NUM_BINS = DefNumBins
) (
  input  logic        clk,
  input  logic        we,
  input  logic [7:0]  waddr,
  input  logic [32:0] wdata,
  input  logic [7:0]  raddr,
  output logic [32:0] rdata
);
  localparam int unsigned AW = $clog2(NUM_BINS);
  logic [32:0] mem [NUM_BINS];

  always_ff @(posedge clk) begin
    if (we) mem[waddr[AW-1:0]] <= wdata;
    rdata <= mem[raddr[AW-1:0]];
  end
endmodule

### src/sbpa_checker.sv
module sbpa_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_bin_index,
  input logic [7:0] out_filled_bins
);
  a_no_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("ready while result pending");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready after accept");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bin_index))
    else $error("result dropped");
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_filled_bins <= 8'd255) else $error("fill count");
endmodule

bind spectrum_bin_peak_accumulator sbpa_checker u_chk (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_bin_index(out_ch.bin_index), .out_filled_bins(out_ch.filled_bins)
);
